### hw/rtl/lpfd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Deframer package
// Shared types and constants for the length-prefixed frame deframer.
// ----------------------------------------------------------------------------
package lpfd_pkg;

   // Header is start byte, command byte and length byte.
   localparam int unsigned HEADER_BYTES = 3;

   // Configuration register map.
   localparam int unsigned CSR_INDEX_WIDTH = 1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_START_BYTE  = 1'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MAX_PAYLOAD = 1'd1;

   // Register reset values.
   localparam logic [7:0] START_BYTE_RESET  = 8'hFE;
   localparam logic [7:0] MAX_PAYLOAD_RESET = 8'hFD;

   // One result word.
   typedef struct packed {
      logic [7:0]  data_byte;
      logic [8:0]  byte_index;
      logic [7:0]  command;
      logic [7:0]  payload_length;
      logic        frame_end;
      logic        frame_error;
      logic [15:0] frame_count;
   } result_type;

endpackage

### hw/rtl/lpfd_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Deframer parser
// Holds the frame state and forms the result word for one received byte.
// ----------------------------------------------------------------------------
module lpfd_parser (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step_fire,
   input  logic [7:0]           step_byte,
   input  logic [7:0]           start_byte,
   input  logic [7:0]           max_payload,
   output logic                 produce,
   output lpfd_pkg::result_type result
);

   logic        in_frame_ff,     in_frame_in;
   logic [8:0]  byte_counter_ff, byte_counter_in;
   logic [7:0]  command_ff,      command_in;
   logic [7:0]  length_ff,       length_in;
   logic [15:0] frames_ff,       frames_in;

   logic        is_command;
   logic        is_length;
   logic        length_error;
   logic        last_byte;
   logic [7:0]  length_next;
   logic [9:0]  end_index;

   // Header decode for a byte inside a frame.
   assign is_command   = (byte_counter_ff == 9'd1);
   assign is_length    = (byte_counter_ff == 9'd2);
   assign length_error = in_frame_ff && is_length && (step_byte > max_payload);

   // Length in force for this byte, including a length byte arriving now.
   assign length_next = (in_frame_ff && is_length) ? step_byte : length_ff;

   // The last byte sits at index length + 2.
   assign end_index = {2'b00, length_next} + 10'(lpfd_pkg::HEADER_BYTES - 1);
   assign last_byte = in_frame_ff && !length_error && (byte_counter_ff >= 9'd2)
                      && ({1'b0, byte_counter_ff} == end_index);

   // Next state and result word.
   always_comb begin
      in_frame_in     = in_frame_ff;
      byte_counter_in = byte_counter_ff;
      command_in      = command_ff;
      length_in       = length_ff;
      frames_in       = frames_ff;
      produce         = 1'b0;
      if (!in_frame_ff) begin
         if (step_byte == start_byte) begin
            produce         = 1'b1;
            in_frame_in     = 1'b1;
            byte_counter_in = 9'd1;
            command_in      = 8'd0;
            length_in       = 8'd0;
         end
      end else begin
         produce = 1'b1;
         if (is_command) begin
            command_in = step_byte;
         end
         if (is_length) begin
            length_in = step_byte;
         end
         if (length_error) begin
            in_frame_in     = 1'b0;
            byte_counter_in = 9'd0;
         end else if (last_byte) begin
            frames_in       = frames_ff + 16'd1;
            in_frame_in     = 1'b0;
            byte_counter_in = 9'd0;
         end else begin
            byte_counter_in = byte_counter_ff + 9'd1;
         end
      end
   end

   always_comb begin
      result.data_byte      = step_byte;
      result.byte_index     = in_frame_ff ? byte_counter_ff : 9'd0;
      result.command        = command_in;
      result.payload_length = length_in;
      result.frame_end      = last_byte;
      result.frame_error    = length_error;
      result.frame_count    = frames_in;
   end

   // Frame state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_frame_ff     <= 1'b0;
         byte_counter_ff <= 9'd0;
         command_ff      <= 8'd0;
         length_ff       <= 8'd0;
         frames_ff       <= 16'd0;
      end else if (step_fire) begin
         in_frame_ff     <= in_frame_in;
         byte_counter_ff <= byte_counter_in;
         command_ff      <= command_in;
         length_ff       <= length_in;
         frames_ff       <= frames_in;
      end
   end

endmodule

### hw/rtl/lpfd_out_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Deframer output stage
// Result register with valid/stall handshake toward the receiver.
// ----------------------------------------------------------------------------
module lpfd_out_stage (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 load,
   input  lpfd_pkg::result_type load_word,
   output logic                 free,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output lpfd_pkg::result_type rsp_word
);

   logic                 valid_ff, valid_in;
   lpfd_pkg::result_type word_ff;

   // The register can take a word when empty or when its word leaves now.
   assign free = !valid_ff || !rsp_stall;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (!rsp_stall) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Payload needs no reset.
   always_ff @(posedge clock) begin
      if (load) begin
         word_ff <= load_word;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_word  = word_ff;

endmodule

### hw/rtl/length_prefixed_frame_deframer_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Length-prefixed frame deframer
// Finds start-byte framed packets in a byte stream and tags each frame byte.
// ----------------------------------------------------------------------------
// Usage:
//   The req channel carries one received byte per word. While idle, bytes are
//   dropped until one matches the start byte register; that byte opens a
//   frame. Every byte inside a frame leaves on the rsp channel with its index,
//   the command and length seen so far, end and error flags and the running
//   completed-frame count. A length above max_payload is flagged and the frame
//   is dropped. The csr port writes start_byte (index 0) and max_payload
//   (index 1) and should be used only while no word is in flight.
//   A byte accepted on req is taken by the input register; the parser result
//   for it is then loaded into the result register, which raises rsp_valid.
//   Throughput is one byte per cycle while the receiver does not stall, set
//   by the parser state update.
//   When the receiver stalls, the result register holds its word and the
//   input register fills; req_stall rises once both are occupied and the
//   held byte gives a word.
//   Reset empties both registers, returns the parser to idle, clears the
//   frame counter and loads start_byte 0xFE and max_payload 0xFD.
// ----------------------------------------------------------------------------
module length_prefixed_frame_deframer_unit (
   input  logic                                 clock,
   input  logic                                 reset,
   // Input channel
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [7:0]                           req_in_byte,
   // Result channel
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [7:0]                           rsp_data_byte,
   output logic [8:0]                           rsp_byte_index,
   output logic [7:0]                           rsp_command,
   output logic [7:0]                           rsp_payload_length,
   output logic                                 rsp_frame_end,
   output logic                                 rsp_frame_error,
   output logic [15:0]                          rsp_frame_count,
   // Configuration port
   input  logic                                 csr_write_enable,
   input  logic [lpfd_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [7:0]                           csr_write_data
);

   logic                 in_valid_ff, in_valid_in;
   logic [7:0]           in_byte_ff;
   logic [7:0]           start_byte_ff;
   logic [7:0]           max_payload_ff;
   logic                 produce;
   logic                 advance;
   logic                 out_free;
   logic                 req_fire;
   lpfd_pkg::result_type step_result;
   lpfd_pkg::result_type rsp_word;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         start_byte_ff  <= lpfd_pkg::START_BYTE_RESET;
         max_payload_ff <= lpfd_pkg::MAX_PAYLOAD_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            lpfd_pkg::CSR_START_BYTE:  start_byte_ff  <= csr_write_data;
            lpfd_pkg::CSR_MAX_PAYLOAD: max_payload_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   // A held byte moves on when it gives no result or the result register frees.
   assign advance   = in_valid_ff && (out_free || !produce);
   assign req_stall = in_valid_ff && !advance;
   assign req_fire  = req_valid && !req_stall;

   // Input register.
   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_fire) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_byte_ff <= req_in_byte;
      end
   end

   // Frame parser.
   lpfd_parser u_parser (
      .clock       (clock),
      .reset       (reset),
      .step_fire   (advance),
      .step_byte   (in_byte_ff),
      .start_byte  (start_byte_ff),
      .max_payload (max_payload_ff),
      .produce     (produce),
      .result      (step_result)
   );

   // Result register.
   lpfd_out_stage u_out_stage (
      .clock     (clock),
      .reset     (reset),
      .load      (advance && produce),
      .load_word (step_result),
      .free      (out_free),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

   assign rsp_data_byte      = rsp_word.data_byte;
   assign rsp_byte_index     = rsp_word.byte_index;
   assign rsp_command        = rsp_word.command;
   assign rsp_payload_length = rsp_word.payload_length;
   assign rsp_frame_end      = rsp_word.frame_end;
   assign rsp_frame_error    = rsp_word.frame_error;
   assign rsp_frame_count    = rsp_word.frame_count;

endmodule

### test/length_prefixed_frame_deframer_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Deframer testbench
// Drives byte streams into the length-prefixed frame deframer and checks
// every tagged output word against a cycle-free model of the parser. A short
// directed table covers the header corner cases and the register extremes.
// Random frames follow under several register settings, with bursty input
// and a receiver that stalls on its own pattern.
// ----------------------------------------------------------------------------
module length_prefixed_frame_deframer_unit_tb;

   localparam int RSP_LATENCY     = 2;
   localparam int SETTLE_CYCLES   = RSP_LATENCY + 2;
   localparam int HOLD_OFF_CYCLES = 60;
   localparam int QUIET_LIMIT     = 2000;
   localparam int PHASE_WORDS     = 65;
   localparam int RANDOM_PHASES   = 5;

   typedef enum logic [0:0] {ROW_BYTE, ROW_CONFIG} row_kind_type;
   typedef enum logic [1:0] {
      FLOW_FREE, FLOW_RANDOM, FLOW_PERIODIC, FLOW_BLOCKED
   } stall_mode_type;
   typedef enum logic [2:0] {
      SHAPE_NOISE, SHAPE_TRUNCATED, SHAPE_OVERSIZE, SHAPE_FULL, SHAPE_NORMAL
   } frame_shape_type;

   // One directed row: a byte to send or a register setting to apply.
   typedef struct {
      row_kind_type         kind;
      logic [7:0]           first;
      logic [7:0]           second;
      bit                   pinned;
      bit                   pin_has;
      lpfd_pkg::result_type pin_word;
   } row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [7:0] req_in_byte = 8'h00;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [7:0] rsp_data_byte;
   logic [8:0] rsp_byte_index;
   logic [7:0] rsp_command;
   logic [7:0] rsp_payload_length;
   logic rsp_frame_end;
   logic rsp_frame_error;
   logic [15:0] rsp_frame_count;
   logic csr_write_enable = 1'b0;
   logic [lpfd_pkg::CSR_INDEX_WIDTH-1:0] csr_index = lpfd_pkg::CSR_START_BYTE;
   logic [7:0] csr_write_data = 8'h00;

   // Register copies and parser state of the model.
   logic [7:0] cfg_start_byte = lpfd_pkg::START_BYTE_RESET;
   logic [7:0] cfg_max_payload = lpfd_pkg::MAX_PAYLOAD_RESET;
   bit frame_open = 1'b0;
   logic [8:0] next_index = '0;
   logic [7:0] held_command = '0;
   logic [7:0] held_length = '0;
   logic [15:0] frames_done = '0;

   lpfd_pkg::result_type expected_words[$];
   lpfd_pkg::result_type oldest_word;
   int words_predicted = 0;
   int mismatches = 0;
   int burst_left = 0;
   bit hold_off_request = 1'b0;

   length_prefixed_frame_deframer_unit i_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_in_byte        (req_in_byte),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_data_byte      (rsp_data_byte),
      .rsp_byte_index     (rsp_byte_index),
      .rsp_command        (rsp_command),
      .rsp_payload_length (rsp_payload_length),
      .rsp_frame_end      (rsp_frame_end),
      .rsp_frame_error    (rsp_frame_error),
      .rsp_frame_count    (rsp_frame_count),
      .csr_write_enable   (csr_write_enable),
      .csr_index          (csr_index),
      .csr_write_data     (csr_write_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Parser model: returns 1 when the byte yields an output word.
   function automatic bit predict_frame_word(input logic [7:0] in_byte,
                                             output lpfd_pkg::result_type word);
      logic [8:0] idx;
      bit ends;
      bit too_long;
      word = '0;
      ends = 1'b0;
      too_long = 1'b0;
      if (!frame_open) begin
         if (in_byte != cfg_start_byte) return 1'b0;
         frame_open = 1'b1;
         held_command = '0;
         held_length = '0;
         next_index = 9'd1;
         word.data_byte = in_byte;
         word.frame_count = frames_done;
         return 1'b1;
      end
      idx = next_index;
      if (idx == 9'd1) begin
         held_command = in_byte;
      end else if (idx == 9'd2) begin
         held_length = in_byte;
         too_long = (in_byte > cfg_max_payload);
      end
      // An oversized length drops the frame; otherwise the frame closes on
      // its last payload byte, or on the length byte when it is zero.
      if (too_long) begin
         frame_open = 1'b0;
         next_index = '0;
      end else if (idx >= 9'd2 &&
                   int'(idx) + 1 == int'(held_length) + int'(lpfd_pkg::HEADER_BYTES)) begin
         ends = 1'b1;
         frames_done = frames_done + 16'd1;
         frame_open = 1'b0;
         next_index = '0;
      end else begin
         next_index = idx + 9'd1;
      end
      word.data_byte = in_byte;
      word.byte_index = idx;
      word.command = held_command;
      word.payload_length = held_length;
      word.frame_end = ends;
      word.frame_error = too_long;
      word.frame_count = frames_done;
      return 1'b1;
   endfunction

   function automatic row_type byte_row(input logic [7:0] value);
      row_type row;
      row = '{ROW_BYTE, value, 8'h00, 1'b0, 1'b0, '0};
      return row;
   endfunction

   function automatic row_type pinned_row(input logic [7:0] value, input bit has,
                                          input lpfd_pkg::result_type word);
      row_type row;
      row = '{ROW_BYTE, value, 8'h00, 1'b1, has, word};
      return row;
   endfunction

   function automatic row_type config_row(input logic [7:0] start_value,
                                          input logic [7:0] max_value);
      row_type row;
      row = '{ROW_CONFIG, start_value, max_value, 1'b0, 1'b0, '0};
      return row;
   endfunction

   // Offer one byte in the current burst, then record what it should produce.
   task automatic offer(input logic [7:0] value, input bit pinned = 1'b0,
                        input bit pin_has = 1'b0,
                        input lpfd_pkg::result_type pin_word = '0);
      lpfd_pkg::result_type word;
      bit has;
      if (burst_left == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
         burst_left = $urandom_range(1, 24);
      end
      req_valid <= 1'b1;
      req_in_byte <= value;
      do @(posedge clock); while (req_stall);
      burst_left--;
      has = predict_frame_word(value, word);
      if (pinned) begin
         has = pin_has;
         word = pin_word;
      end
      if (has) begin
         expected_words.push_back(word);
         words_predicted++;
      end
   endtask

   // Stop sending and wait until every word has come out.
   task automatic settle();
      req_valid <= 1'b0;
      while (expected_words.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_config(input logic [7:0] start_value, input logic [7:0] max_value);
      csr_write_enable <= 1'b1;
      csr_index <= lpfd_pkg::CSR_START_BYTE;
      csr_write_data <= start_value;
      @(posedge clock);
      csr_index <= lpfd_pkg::CSR_MAX_PAYLOAD;
      csr_write_data <= max_value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      cfg_start_byte = start_value;
      cfg_max_payload = max_value;
   endtask

   task automatic check_field(input string field, input logic [15:0] want,
                              input logic [15:0] got);
      if (want !== got) begin
         $error("%s: expected %0h, got %0h", field, want, got);
         mismatches++;
      end
   endtask

   // Compare each accepted output word with the oldest expected one.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_words.size() == 0) begin
            $error("unexpected word: byte %0h index %0d", rsp_data_byte, rsp_byte_index);
            mismatches++;
         end else begin
            oldest_word = expected_words.pop_front();
            check_field("data_byte", 16'(oldest_word.data_byte), 16'(rsp_data_byte));
            check_field("byte_index", 16'(oldest_word.byte_index), 16'(rsp_byte_index));
            check_field("command", 16'(oldest_word.command), 16'(rsp_command));
            check_field("payload_length", 16'(oldest_word.payload_length),
                        16'(rsp_payload_length));
            check_field("frame_end", 16'(oldest_word.frame_end), 16'(rsp_frame_end));
            check_field("frame_error", 16'(oldest_word.frame_error),
                        16'(rsp_frame_error));
            check_field("frame_count", oldest_word.frame_count, rsp_frame_count);
         end
      end
   end

   // Receiver stall pattern, with one long hold-off on request.
   initial begin
      stall_mode_type mode;
      int span;
      while (reset) @(posedge clock);
      forever begin
         if (hold_off_request) begin
            hold_off_request = 1'b0;
            rsp_stall <= 1'b1;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
         end else begin
            mode = stall_mode_type'($urandom_range(0, 3));
            span = $urandom_range(4, 40);
            for (int c = 0; c < span; c++) begin
               case (mode)
                  FLOW_FREE: begin
                     rsp_stall <= 1'b0;
                  end
                  FLOW_RANDOM: begin
                     rsp_stall <= 1'($urandom_range(0, 1));
                  end
                  FLOW_PERIODIC: begin
                     rsp_stall <= (c % 3 == 0);
                  end
                  default: begin
                     rsp_stall <= (c < 6);
                  end
               endcase
               @(posedge clock);
            end
         end
      end
   end

   // Give up when no word moves on either side for too long.
   initial begin
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet = 0;
         else quiet++;
      end
      $display("Simulation FAILED");
      $finish;
   end

   // Reset, directed table, then random frames under several settings.
   initial begin
      row_type directed_rows[$];
      frame_shape_type shape;
      int base;
      int pick;
      int len;
      bit long_frame_sent;
      bit hold_off_issued;
      long_frame_sent = 1'b0;
      hold_off_issued = 1'b0;

      // Reset values: start byte 0xFE, largest length 0xFD.
      directed_rows.push_back(pinned_row(8'h00, 1'b0, '0));
      directed_rows.push_back(pinned_row(8'hFF, 1'b0, '0));
      directed_rows.push_back(pinned_row(8'hFE, 1'b1,
         lpfd_pkg::result_type'{8'hFE, 9'd0, 8'h00, 8'h00, 1'b0, 1'b0, 16'd0}));
      // The start byte value inside a frame is plain data.
      directed_rows.push_back(byte_row(8'hFE));
      // A zero length closes the frame on its length byte.
      directed_rows.push_back(pinned_row(8'h00, 1'b1,
         lpfd_pkg::result_type'{8'h00, 9'd2, 8'hFE, 8'h00, 1'b1, 1'b0, 16'd1}));
      // One above the largest length drops the frame with an error.
      directed_rows.push_back(byte_row(8'hFE));
      directed_rows.push_back(byte_row(8'hFF));
      directed_rows.push_back(pinned_row(8'hFE, 1'b1,
         lpfd_pkg::result_type'{8'hFE, 9'd2, 8'hFF, 8'hFE, 1'b0, 1'b1, 16'd1}));
      directed_rows.push_back(byte_row(8'hFE));
      directed_rows.push_back(byte_row(8'h00));
      directed_rows.push_back(byte_row(8'h02));
      directed_rows.push_back(byte_row(8'hAA));
      directed_rows.push_back(byte_row(8'h55));
      directed_rows.push_back(pinned_row(8'h55, 1'b0, '0));
      // Lowest register values: every nonzero length is too long.
      directed_rows.push_back(config_row(8'h00, 8'h00));
      directed_rows.push_back(pinned_row(8'h00, 1'b1,
         lpfd_pkg::result_type'{8'h00, 9'd0, 8'h00, 8'h00, 1'b0, 1'b0, 16'd2}));
      directed_rows.push_back(byte_row(8'h01));
      directed_rows.push_back(pinned_row(8'h01, 1'b1,
         lpfd_pkg::result_type'{8'h01, 9'd2, 8'h01, 8'h01, 1'b0, 1'b1, 16'd2}));
      directed_rows.push_back(byte_row(8'h00));
      directed_rows.push_back(byte_row(8'hFF));
      directed_rows.push_back(pinned_row(8'h00, 1'b1,
         lpfd_pkg::result_type'{8'h00, 9'd2, 8'hFF, 8'h00, 1'b1, 1'b0, 16'd3}));
      // Highest register values.
      directed_rows.push_back(config_row(8'hFF, 8'hFF));
      directed_rows.push_back(pinned_row(8'h00, 1'b0, '0));
      directed_rows.push_back(byte_row(8'hFF));
      directed_rows.push_back(byte_row(8'h80));
      directed_rows.push_back(byte_row(8'h01));
      directed_rows.push_back(byte_row(8'h7F));

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         if (directed_rows[i].kind == ROW_CONFIG) begin
            settle();
            set_config(directed_rows[i].first, directed_rows[i].second);
         end else begin
            offer(directed_rows[i].first, directed_rows[i].pinned,
                  directed_rows[i].pin_has, directed_rows[i].pin_word);
         end
      end

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         settle();
         case (phase)
            0: set_config(8'($urandom_range(0, 255)), 8'($urandom_range(4, 12)));
            1: set_config(8'hFF, 8'hFF);
            2: set_config(8'h00, 8'h00);
            default: set_config(8'($urandom_range(0, 255)), 8'($urandom_range(0, 20)));
         endcase
         base = words_predicted;
         while (words_predicted - base < PHASE_WORDS) begin
            // Once the first setting is running, let the receiver block so
            // the input side backs up.
            if (phase == 0 && !hold_off_issued && words_predicted - base >= 20) begin
               hold_off_issued = 1'b1;
               hold_off_request = 1'b1;
            end
            pick = $urandom_range(0, 9);
            shape = (pick == 0) ? SHAPE_NOISE :
                    (pick == 1) ? SHAPE_TRUNCATED :
                    (pick == 2) ? SHAPE_OVERSIZE :
                    (pick == 3) ? SHAPE_FULL : SHAPE_NORMAL;
            // With the widest length allowed, a broken header would swallow
            // hundreds of bytes, so keep those frames well formed.
            if (cfg_max_payload == 8'hFF &&
                (shape == SHAPE_TRUNCATED || shape == SHAPE_OVERSIZE)) begin
               shape = SHAPE_NORMAL;
            end
            if (shape == SHAPE_NOISE) begin
               repeat ($urandom_range(1, 3)) offer(8'($urandom_range(0, 255)));
            end else if (shape == SHAPE_TRUNCATED) begin
               offer(cfg_start_byte);
               repeat ($urandom_range(0, 1)) offer(8'($urandom_range(0, 255)));
            end else begin
               if (cfg_max_payload == 8'hFF && !long_frame_sent) begin
                  len = 255;
                  long_frame_sent = 1'b1;
               end else if (shape == SHAPE_OVERSIZE) begin
                  len = $urandom_range(int'(cfg_max_payload) + 1, 255);
               end else if (shape == SHAPE_FULL) begin
                  len = (cfg_max_payload > 8'd24) ? 24 : int'(cfg_max_payload);
               end else begin
                  len = $urandom_range(0, (cfg_max_payload > 8'd8) ? 8 : int'(cfg_max_payload));
               end
               offer(cfg_start_byte);
               offer(8'($urandom_range(0, 255)));
               offer(len[7:0]);
               if (len <= int'(cfg_max_payload)) begin
                  repeat (len) offer(8'($urandom_range(0, 255)));
               end
            end
         end
      end

      req_valid <= 1'b0;
      while (expected_words.size() != 0) @(posedge clock);
      repeat (2 * SETTLE_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

### sim.f
hw/rtl/lpfd_pkg.sv
hw/rtl/lpfd_parser.sv
hw/rtl/lpfd_out_stage.sv
hw/rtl/length_prefixed_frame_deframer_unit.sv
test/length_prefixed_frame_deframer_unit_tb.sv
